// ===== sv/rrtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrtd_pkg: shared types and constants of the round-robin task dispatcher
// Field widths, done-bitmap geometry, queue depth, result codes and the
// structs that pass between the front, the queue and the back end.
// ----------------------------------------------------------------------------
package rrtd_pkg;

  // task store geometry
  localparam int MAX_TASKS = 1024;
  localparam int TASK_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = 11;
  localparam int JOB_W     = 16;

  // done bitmap is kept in rows of ROW_W bits
  localparam int ROW_W     = 32;
  localparam int ROW_OFF_W = $clog2(ROW_W);
  localparam int ROWS      = MAX_TASKS / ROW_W;
  localparam int ROW_IDX_W = TASK_W - ROW_OFF_W;

  // remainder unit steps
  localparam int STEP_W    = $clog2(TASK_W);

  // front-to-back queue
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  // stream widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JOB_NUMBER = 2'd1;

  // report verdict codes
  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_ACC  = 2'd1,
    VERDICT_REJ  = 2'd2
  } verdict_e;

  // assignment kind codes
  typedef enum logic [1:0] {
    KIND_WAIT  = 2'd0,
    KIND_WORK  = 2'd1,
    KIND_FETCH = 2'd2
  } kind_e;

  // classified visit as queued between front and back
  typedef struct packed {
    logic              has_report;
    logic              pre_ok;
    logic              stale;
    logic [TASK_W-1:0] task_idx;
  } entry_t;

  // configuration as seen by the back end
  typedef struct packed {
    logic             clear;
    logic [CNT_W-1:0] n_eff;
  } cfg_t;

endpackage

// ===== sv/round_robin_task_dispatcher_top.sv =====
// Path: a visit passes the front and the queue, then the back end's idle,
// report (matching in-range reports only), modulo, divide (only when the scan
// pointer lies beyond the task count), scan and output states; the scan steps
// through the bitmap rows in turn from the pointer's row. The back end takes
// one visit at a time and pops the next only when idle; the queue holds input.
// Reset: async active low; task_count 1, job 0, all tasks open, pointer 0.
// ----------------------------------------------------------------------------
// round_robin_task_dispatcher_top: round-robin task dispatcher
// Config registers, classifying front, visit queue and dispatch back end.
// ----------------------------------------------------------------------------
module round_robin_task_dispatcher_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [rrtd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rrtd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // visit stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rrtd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // report_job, report_task
  input  logic                              s_axis_tuser,  // has_report
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // report_verdict, assign_task, tasks_left, job_finished
  output logic [rrtd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [1:0]                        m_axis_tuser   // assign_kind
);

  logic [rrtd_pkg::CNT_W-1:0] task_count_q;
  logic [rrtd_pkg::JOB_W-1:0] job_number_q;
  logic [rrtd_pkg::CNT_W-1:0] n_eff;
  rrtd_pkg::cfg_t             cfg;
  logic                       q_full;
  logic                       q_push;
  logic                       q_valid;
  logic                       q_pop;
  rrtd_pkg::entry_t           entry_in;
  rrtd_pkg::entry_t           entry_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= rrtd_pkg::CNT_W'(1);
      job_number_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rrtd_pkg::REG_TASK_COUNT: task_count_q <= cfg_wdata_i[rrtd_pkg::CNT_W-1:0];
        rrtd_pkg::REG_JOB_NUMBER: job_number_q <= cfg_wdata_i[rrtd_pkg::JOB_W-1:0];
        default: ;
      endcase
    end
  end

  // task count saturated to the store size, zero read as one
  always_comb begin
    if (task_count_q == '0) begin
      n_eff = rrtd_pkg::CNT_W'(1);
    end else if (task_count_q > rrtd_pkg::CNT_W'(rrtd_pkg::MAX_TASKS)) begin
      n_eff = rrtd_pkg::CNT_W'(rrtd_pkg::MAX_TASKS);
    end else begin
      n_eff = task_count_q;
    end
  end

  assign cfg.clear = cfg_we_i && (cfg_idx_i == rrtd_pkg::REG_JOB_NUMBER);
  assign cfg.n_eff = n_eff;

  rrtd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .job_number_i  (job_number_q),
    .n_eff_i       (n_eff),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (entry_in)
  );

  rrtd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (entry_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (entry_out)
  );

  rrtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_entry_i   (entry_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser)
  );

endmodule

// ===== sv/rrtd_front.sv =====
// ----------------------------------------------------------------------------
// rrtd_front: visit classifier
// Unpacks an incoming worker visit and checks job match and task range
// against the current configuration before it enters the queue.
// ----------------------------------------------------------------------------
module rrtd_front (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rrtd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic [rrtd_pkg::JOB_W-1:0]       job_number_i,
  input  logic [rrtd_pkg::CNT_W-1:0]       n_eff_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output rrtd_pkg::entry_t                 q_entry_o
);

  logic [rrtd_pkg::JOB_W-1:0]  rep_job;
  logic [rrtd_pkg::TASK_W-1:0] rep_task;
  logic                        job_match;
  logic                        in_range;

  // field unpack
  assign rep_job  = s_axis_tdata[rrtd_pkg::JOB_W-1:0];
  assign rep_task = s_axis_tdata[rrtd_pkg::JOB_W +: rrtd_pkg::TASK_W];

  // classification
  assign job_match = (rep_job == job_number_i);
  assign in_range  = (rrtd_pkg::CNT_W'(rep_task) < n_eff_i);

  assign q_entry_o.has_report = s_axis_tuser;
  assign q_entry_o.pre_ok     = job_match && in_range;
  assign q_entry_o.stale      = !job_match;
  assign q_entry_o.task_idx   = rep_task;

  // handshake
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

endmodule

// ===== sv/rrtd_queue.sv =====
// ----------------------------------------------------------------------------
// rrtd_queue: short queue of classified visits
// Two-entry fifo that lets the front keep accepting while the back end
// is busy updating the task store and scanning.
// ----------------------------------------------------------------------------
module rrtd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rrtd_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output rrtd_pkg::entry_t entry_o
);

  rrtd_pkg::entry_t                slots_q [rrtd_pkg::QDEPTH];
  logic [rrtd_pkg::QPTR_W-1:0]     wr_ptr_q;
  logic [rrtd_pkg::QPTR_W-1:0]     rd_ptr_q;
  logic [rrtd_pkg::QPTR_W:0]       cnt_q;

  assign full_o  = (cnt_q == (rrtd_pkg::QPTR_W+1)'(rrtd_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slots_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/rrtd_back.sv =====
// ----------------------------------------------------------------------------
// rrtd_back: dispatch engine
// Applies a report to the done bitmap, reduces the scan pointer into range,
// scans the bitmap one row per cycle for the next task that is not done and
// registers the result word.
// ----------------------------------------------------------------------------
module rrtd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rrtd_pkg::cfg_t                    cfg_i,
  input  logic                              q_valid_i,
  input  rrtd_pkg::entry_t                  q_entry_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rrtd_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic [1:0]                        out_kind_o
);

  localparam int DIV_W = rrtd_pkg::TASK_W + rrtd_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RPT,
    S_MOD,
    S_DIV,
    S_SCAN,
    S_OUT
  } state_e;

  state_e                               state_q, state_d;
  rrtd_pkg::entry_t                     item_q, item_d;
  rrtd_pkg::verdict_e                   verdict_q, verdict_d;
  rrtd_pkg::kind_e                      kind_q, kind_d;
  logic [rrtd_pkg::TASK_W-1:0]          res_task_q, res_task_d;
  logic [rrtd_pkg::TASK_W-1:0]          ptr_q, ptr_d;
  logic [rrtd_pkg::TASK_W-1:0]          pos_q, pos_d;
  logic [rrtd_pkg::STEP_W-1:0]          step_q, step_d;
  logic [rrtd_pkg::ROW_IDX_W-1:0]       row_q, row_d;
  logic                                 first_q, first_d;
  logic [rrtd_pkg::ROW_IDX_W:0]         visits_q, visits_d;
  logic [rrtd_pkg::CNT_W-1:0]           remain_q, remain_d;
  logic [rrtd_pkg::ROWS-1:0]            row_vld_q, row_vld_d;
  logic                                 out_valid_q, out_valid_d;
  logic [rrtd_pkg::OUT_DATA_W-1:0]      out_data_q, out_data_d;
  logic [1:0]                           out_kind_q, out_kind_d;

  // done bitmap memory
  logic [rrtd_pkg::ROW_W-1:0]           mem_q [rrtd_pkg::ROWS];
  logic [rrtd_pkg::ROW_W-1:0]           rd_q;
  logic                                 mem_we;
  logic [rrtd_pkg::ROW_W-1:0]           mem_wdata;

  logic [rrtd_pkg::ROW_W-1:0]           row_data;
  logic [rrtd_pkg::CNT_W-1:0]           n_m1;
  logic [rrtd_pkg::ROW_IDX_W-1:0]       last_row;
  logic [DIV_W-1:0]                     div_sub;
  logic [DIV_W-1:0]                     pos_ext;
  logic [rrtd_pkg::TASK_W-1:0]          pos_red;
  logic [rrtd_pkg::ROW_W-1:0]           cand;
  logic [rrtd_pkg::ROW_OFF_W-1:0]       hit_j;
  logic [rrtd_pkg::TASK_W-1:0]          found;
  logic [rrtd_pkg::CNT_W-1:0]           found_nx;

  // a row never written since the last clear reads as all open
  assign row_data = row_vld_q[row_q] ? rd_q : '0;

  assign n_m1     = cfg_i.n_eff - rrtd_pkg::CNT_W'(1);
  assign last_row = n_m1[rrtd_pkg::TASK_W-1:rrtd_pkg::ROW_OFF_W];

  // one restoring step of pointer modulo task count
  assign div_sub = DIV_W'(cfg_i.n_eff) << step_q;
  assign pos_ext = DIV_W'(pos_q);
  assign pos_red = (pos_ext >= div_sub) ? (pos_q - div_sub[rrtd_pkg::TASK_W-1:0]) : pos_q;

  // candidate tasks in the current row
  always_comb begin
    for (int j = 0; j < rrtd_pkg::ROW_W; j++) begin
      cand[j] = !row_data[j]
             && (rrtd_pkg::CNT_W'({row_q, rrtd_pkg::ROW_OFF_W'(j)}) < cfg_i.n_eff)
             && (!first_q || (rrtd_pkg::ROW_OFF_W'(j) >= pos_q[rrtd_pkg::ROW_OFF_W-1:0]));
    end
  end

  // lowest candidate wins
  always_comb begin
    hit_j = '0;
    for (int j = rrtd_pkg::ROW_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_j = rrtd_pkg::ROW_OFF_W'(j);
      end
    end
  end

  assign found    = {row_q, hit_j};
  assign found_nx = rrtd_pkg::CNT_W'(found) + rrtd_pkg::CNT_W'(1);

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;

  // next-state and datapath
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    verdict_d   = verdict_q;
    kind_d      = kind_q;
    res_task_d  = res_task_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    step_d      = step_q;
    row_d       = row_q;
    first_d     = first_q;
    visits_d    = visits_q;
    remain_d    = remain_q;
    row_vld_d   = row_vld_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    mem_we      = 1'b0;
    mem_wdata   = row_data;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          item_d = q_entry_i;
          row_d  = q_entry_i.task_idx[rrtd_pkg::TASK_W-1:rrtd_pkg::ROW_OFF_W];
          if (q_entry_i.has_report && q_entry_i.pre_ok) begin
            state_d = S_RPT;
          end else begin
            verdict_d = q_entry_i.has_report ? rrtd_pkg::VERDICT_REJ : rrtd_pkg::VERDICT_NONE;
            state_d   = S_MOD;
          end
        end
      end

      // mark the reported task done unless it already is
      S_RPT: begin
        if (!row_data[item_q.task_idx[rrtd_pkg::ROW_OFF_W-1:0]]) begin
          mem_we    = 1'b1;
          mem_wdata = row_data
                    | (rrtd_pkg::ROW_W'(1) << item_q.task_idx[rrtd_pkg::ROW_OFF_W-1:0]);
          row_vld_d[row_q] = 1'b1;
          if (remain_q != '0) begin
            remain_d = remain_q - rrtd_pkg::CNT_W'(1);
          end
          verdict_d = rrtd_pkg::VERDICT_ACC;
        end else begin
          verdict_d = rrtd_pkg::VERDICT_REJ;
        end
        state_d = S_MOD;
      end

      // pointer already in range: start the scan right away, else reduce it first
      S_MOD: begin
        pos_d = ptr_q;
        if (rrtd_pkg::CNT_W'(ptr_q) < cfg_i.n_eff) begin
          row_d    = ptr_q[rrtd_pkg::TASK_W-1:rrtd_pkg::ROW_OFF_W];
          first_d  = 1'b1;
          visits_d = '0;
          state_d  = S_SCAN;
        end else begin
          step_d  = rrtd_pkg::STEP_W'(rrtd_pkg::TASK_W - 1);
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        pos_d = pos_red;
        if (step_q == '0) begin
          row_d    = pos_red[rrtd_pkg::TASK_W-1:rrtd_pkg::ROW_OFF_W];
          first_d  = 1'b1;
          visits_d = '0;
          state_d  = S_SCAN;
        end else begin
          step_d = step_q - 1'b1;
        end
      end

      // one bitmap row per cycle, wrapping at the last used row
      S_SCAN: begin
        if (cand != '0) begin
          kind_d     = item_q.stale ? rrtd_pkg::KIND_FETCH : rrtd_pkg::KIND_WORK;
          res_task_d = found;
          ptr_d      = (found_nx >= cfg_i.n_eff) ? '0 : found_nx[rrtd_pkg::TASK_W-1:0];
          state_d    = S_OUT;
        end else if (visits_q == ({1'b0, last_row} + 1'b1)) begin
          kind_d     = rrtd_pkg::KIND_WAIT;
          res_task_d = '0;
          state_d    = S_OUT;
        end else begin
          row_d    = (row_q == last_row) ? '0 : row_q + 1'b1;
          first_d  = 1'b0;
          visits_d = visits_q + 1'b1;
        end
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {(remain_q == '0), remain_q, res_task_q, verdict_q};
          out_kind_d  = kind_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // job write restarts the job
    if (cfg_i.clear) begin
      ptr_d     = '0;
      remain_d  = cfg_i.n_eff;
      row_vld_d = '0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      remain_q    <= rrtd_pkg::CNT_W'(1);
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_kind_q  <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      remain_q    <= remain_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      out_kind_q  <= out_kind_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    verdict_q  <= verdict_d;
    kind_q     <= kind_d;
    res_task_q <= res_task_d;
    pos_q      <= pos_d;
    step_q     <= step_d;
    row_q      <= row_d;
    first_q    <= first_d;
    visits_q   <= visits_d;
  end

  // bitmap write and registered read of the next row
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[row_q] <= mem_wdata;
    end
    rd_q <= mem_q[row_d];
  end

endmodule

// ===== sv/rrtd_checker.sv =====
// ----------------------------------------------------------------------------
// rrtd_checker: port-level checks of the task dispatcher
// Watches the result stream for held words and consistent result fields.
// ----------------------------------------------------------------------------
module rrtd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rrtd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);

  logic [1:0]                  verdict;
  logic [rrtd_pkg::TASK_W-1:0] a_task;
  logic [rrtd_pkg::CNT_W-1:0]  left;
  logic                        finished;

  assign verdict  = m_axis_tdata[1:0];
  assign a_task   = m_axis_tdata[2 +: rrtd_pkg::TASK_W];
  assign left     = m_axis_tdata[2 + rrtd_pkg::TASK_W +: rrtd_pkg::CNT_W];
  assign finished = m_axis_tdata[2 + rrtd_pkg::TASK_W + rrtd_pkg::CNT_W];

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // a wait answer carries task zero
  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == rrtd_pkg::KIND_WAIT) |-> (a_task == '0))
    else $error("wait answer with nonzero task");

  // finished flag follows the remaining count
  a_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (finished == (left == '0)))
    else $error("job_finished disagrees with tasks_left");

  // only defined codes leave the block
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((verdict == rrtd_pkg::VERDICT_NONE) || (verdict == rrtd_pkg::VERDICT_ACC)
       || (verdict == rrtd_pkg::VERDICT_REJ))
      && ((m_axis_tuser == rrtd_pkg::KIND_WAIT) || (m_axis_tuser == rrtd_pkg::KIND_WORK)
       || (m_axis_tuser == rrtd_pkg::KIND_FETCH)))
    else $error("undefined verdict or kind code");

  // remaining count never exceeds the store size
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (left <= rrtd_pkg::CNT_W'(rrtd_pkg::MAX_TASKS)))
    else $error("tasks_left beyond store size");

endmodule

bind round_robin_task_dispatcher_top rrtd_checker u_rrtd_checker (.*);

// ===== tb/dispatch_checker.sv =====
// ----------------------------------------------------------------------------
// dispatch_checker: result predictor and scoreboard for the task dispatcher
// Watches the config port and both streams, keeps its own copy of the task
// store, scan pointer and remaining count, predicts the result word of every
// accepted visit and compares each result word field by field.
// ----------------------------------------------------------------------------
module dispatch_checker
  import rrtd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // report_job, report_task
  input  logic                  s_axis_tuser,  // has_report
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // report_verdict, assign_task, tasks_left, job_finished
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,  // assign_kind
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // result word field offsets
  localparam int OFF_TASK = 2;
  localparam int OFF_LEFT = OFF_TASK + TASK_W;
  localparam int OFF_FIN  = OFF_LEFT + CNT_W;

  typedef enum logic [1:0] {
    TASK_OPEN = 2'd0,
    TASK_DONE = 2'd1,
    TASK_WORK = 2'd2
  } task_state_e;

  typedef struct packed {
    verdict_e          verdict;
    kind_e             kind;
    logic [TASK_W-1:0] task_idx;
    logic [CNT_W-1:0]  left;
    logic              finished;
  } visit_result_t;

  // shadow of the dispatcher state
  task_state_e       task_state [MAX_TASKS];
  logic [CNT_W-1:0]  task_count_q;
  logic [JOB_W-1:0]  job_q;
  logic [TASK_W-1:0] scan_ptr;
  logic [CNT_W-1:0]  tasks_open;
  visit_result_t     result_q [$];
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // task count saturated to 1..MAX_TASKS
  function automatic int usable_count();
    if (task_count_q == '0) return 1;
    if (int'(task_count_q) > MAX_TASKS) return MAX_TASKS;
    return int'(task_count_q);
  endfunction

  task automatic clear_job();
    for (int i = 0; i < MAX_TASKS; i++) task_state[i] = TASK_OPEN;
    scan_ptr   = '0;
    tasks_open = CNT_W'(usable_count());
  endtask

  // one worker visit: judge the report, then scan round-robin for a task
  task automatic dispatch_visit(input logic has, input logic [JOB_W-1:0] job,
                                input logic [TASK_W-1:0] tidx,
                                output visit_result_t res);
    int n;
    int pos;
    int tries;
    n   = usable_count();
    res = '0;
    res.verdict = VERDICT_NONE;
    res.kind    = KIND_WAIT;
    if (has) begin
      if (job == job_q && int'(tidx) < n && task_state[tidx] != TASK_DONE) begin
        task_state[tidx] = TASK_DONE;
        if (tasks_open != '0) tasks_open = tasks_open - 1'b1;
        res.verdict = VERDICT_ACC;
      end else begin
        res.verdict = VERDICT_REJ;
      end
    end
    // pointer may lie beyond a shrunk task count
    pos = int'(scan_ptr) % n;
    for (tries = 0; tries < n; tries++) begin
      if (task_state[pos] != TASK_DONE) break;
      pos = (pos + 1 >= n) ? 0 : pos + 1;
    end
    // pointer stays put when nothing is free
    if (tries < n) begin
      res.kind     = (job != job_q) ? KIND_FETCH : KIND_WORK;
      res.task_idx = pos[TASK_W-1:0];
      task_state[pos] = TASK_WORK;
      pos      = (pos + 1 >= n) ? 0 : pos + 1;
      scan_ptr = pos[TASK_W-1:0];
    end
    res.left     = tasks_open;
    res.finished = (tasks_open == '0);
  endtask

  // monitor: compare outgoing words, predict incoming visits, track config
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    visit_result_t want;
    visit_result_t got;
    if (!rst_ni) begin
      task_count_q = CNT_W'(1);
      job_q        = '0;
      clear_job();
      result_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.verdict  = verdict_e'(m_axis_tdata[1:0]);
        got.kind     = kind_e'(m_axis_tuser);
        got.task_idx = m_axis_tdata[OFF_TASK +: TASK_W];
        got.left     = m_axis_tdata[OFF_LEFT +: CNT_W];
        got.finished = m_axis_tdata[OFF_FIN];
        if (result_q.size() == 0) begin
          report_mismatch("result word with no visit pending", int'(m_axis_tdata), 0);
        end else begin
          want = result_q.pop_front();
          if (got.verdict !== want.verdict)
            report_mismatch("report_verdict", got.verdict, want.verdict);
          if (got.kind !== want.kind)
            report_mismatch("assign_kind", got.kind, want.kind);
          if (got.task_idx !== want.task_idx)
            report_mismatch("assign_task", got.task_idx, want.task_idx);
          if (got.left !== want.left)
            report_mismatch("tasks_left", got.left, want.left);
          if (got.finished !== want.finished)
            report_mismatch("job_finished", got.finished, want.finished);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        dispatch_visit(s_axis_tuser, s_axis_tdata[JOB_W-1:0],
                       s_axis_tdata[JOB_W +: TASK_W], want);
        result_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TASK_COUNT: task_count_q = cfg_wdata_i[CNT_W-1:0];
          REG_JOB_NUMBER: begin
            job_q = cfg_wdata_i[JOB_W-1:0];
            clear_job();
          end
          default: ;
        endcase
      end
    end
    pending_o = result_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the round-robin task dispatcher
// Directed visits over the special cases, then random jobs of mostly small
// task counts with well-formed reports, stale jobs and out-of-range noise,
// random idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrtd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int TOTAL_VISITS = 1975;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_FROM   = 800;
  localparam int QUIET_TO     = 1100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  int                    fail_count;
  int                    pending;
  int                    visits_sent = 0;
  logic                  hold_rx = 1'b0;

  round_robin_task_dispatcher_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  dispatch_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  function automatic bit quiet_window();
    return visits_sent >= QUIET_FROM && visits_sent < QUIET_TO;
  endfunction

  function automatic int usable_tasks(input int tc);
    if (tc < 1) return 1;
    if (tc > MAX_TASKS) return MAX_TASKS;
    return tc;
  endfunction

  // receiver with random back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !hold_rx && (quiet_window() || $urandom_range(99) >= 33);
    end
  end

  // one long receiver hold-off so the block fills up and stalls its input
  initial begin
    wait (visits_sent >= HOLD_AT);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // offer one visit word, with random idle cycles ahead of it
  task automatic send_visit(input logic has, input logic [JOB_W-1:0] job,
                            input logic [TASK_W-1:0] tidx);
    while (!quiet_window() && $urandom_range(99) < 33) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= has;
    s_axis_tdata  <= IN_DATA_W'({tidx, job});
    do @(posedge clk_i); while (!s_axis_tready);
    visits_sent++;
  endtask

  // drain every pending result, then let the back end settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int pick_task_count();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(16, 1);
    if (r < 75) return $urandom_range(1024, 17);
    if (r < 83) return 1024;
    if (r < 92) return $urandom_range(2047, 1025);
    return 0;
  endfunction

  // mostly well-formed reports of the current job, the rest noise
  task automatic run_visits(input int count, input logic [JOB_W-1:0] job, input int n);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 72)
        send_visit(1'b1, job, TASK_W'($urandom_range(n - 1, 0)));
      else if (r < 80)
        send_visit(1'b0, job, TASK_W'($urandom));
      else if (r < 88)
        send_visit(1'(($urandom_range(1))), JOB_W'($urandom),
                   TASK_W'($urandom_range(n - 1, 0)));
      else
        send_visit(1'b1, job, TASK_W'($urandom_range(1023, 0)));
    end
  endtask

  // main sequence
  initial begin
    int tc;
    int n;
    int len;
    logic [JOB_W-1:0] job;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset job: one task, finish it, then done and stale reports
    send_visit(1'b0, 16'h0000, 10'd0);
    send_visit(1'b1, 16'h0000, 10'd0);
    send_visit(1'b1, 16'h0000, 10'd0);
    send_visit(1'b1, 16'hFFFF, 10'd0);

    // largest job, top job number, stale worker gets a fetch
    wait_idle();
    write_reg(REG_TASK_COUNT, 16'h0400);
    write_reg(REG_JOB_NUMBER, 16'hFFFF);
    send_visit(1'b0, 16'hFFFF, 10'd1023);
    send_visit(1'b0, 16'h0000, 10'd0);
    send_visit(1'b1, 16'hFFFF, 10'd1023);
    send_visit(1'b1, 16'hFFFF, 10'd1023);
    send_visit(1'b1, 16'hFFFF, 10'd1);
    send_visit(1'b0, 16'hFFFF, 10'd0);

    // count shrunk mid-job: pointer beyond count, out-of-range report
    wait_idle();
    write_reg(REG_TASK_COUNT, 16'd3);
    send_visit(1'b1, 16'hFFFF, 10'd7);
    send_visit(1'b1, 16'hFFFF, 10'd2);

    // zero count acts as one
    wait_idle();
    write_reg(REG_TASK_COUNT, 16'd0);
    write_reg(REG_JOB_NUMBER, 16'h1234);
    send_visit(1'b1, 16'h1234, 10'd1);
    send_visit(1'b1, 16'h1234, 10'd0);

    // oversized count saturates, upper data bits ignored
    wait_idle();
    write_reg(REG_TASK_COUNT, 16'hFFFF);
    write_reg(REG_JOB_NUMBER, 16'h8000);
    send_visit(1'b0, 16'h8000, 10'd0);
    send_visit(1'b1, 16'h8000, 10'd1023);

    // unknown indexes ignored; count grown mid-job, remaining floors at zero
    wait_idle();
    write_reg(REG_TASK_COUNT, 16'd2);
    write_reg(REG_JOB_NUMBER, 16'h00FF);
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'hFFFF);
    send_visit(1'b1, 16'h00FF, 10'd0);
    wait_idle();
    write_reg(REG_TASK_COUNT, 16'd4);
    send_visit(1'b1, 16'h00FF, 10'd1);
    send_visit(1'b1, 16'h00FF, 10'd2);
    send_visit(1'b1, 16'h00FF, 10'd3);
    send_visit(1'b1, 16'h00FF, 10'd0);
    send_visit(1'b0, 16'h00FF, 10'd0);

    // random jobs
    job = 16'h00FF;
    while (visits_sent < TOTAL_VISITS) begin
      tc = pick_task_count();
      wait_idle();
      write_reg(REG_TASK_COUNT, {5'($urandom), 11'(tc)});
      if ($urandom_range(99) >= 20) job = JOB_W'($urandom);
      write_reg(REG_JOB_NUMBER, job);
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
      n   = usable_tasks(tc);
      len = (n <= 16) ? $urandom_range(4 * n + 8, n + 2) : $urandom_range(60, 20);
      run_visits(len, job, n);
      // task count changed while the job is running
      if ($urandom_range(3) == 0) begin
        tc = pick_task_count();
        wait_idle();
        write_reg(REG_TASK_COUNT, CFG_DATA_W'(tc));
        n = usable_tasks(tc);
        run_visits($urandom_range(30, 5), job, n);
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
